/* design/cordic_sine_cosine_unit_defines.svh */
// Assertion macros used by the design file that carries assertions.
`ifndef CORDIC_SINE_COSINE_UNIT_DEFINES_SVH
`define CORDIC_SINE_COSINE_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define CSC_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CSC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/csc_pkg.sv */
// Package with the constants and types of the CORDIC sine and cosine unit.
package csc_pkg;

  typedef logic signed [31:0] word_t;
  typedef logic [4:0]         iter_cnt_t;

  // Configuration register indexes.
  typedef enum logic {
    CFG_ITERATION_COUNT   = 1'b0,
    CFG_SHORT_OUTPUT_MODE = 1'b1
  } cfg_index_t;

  localparam int DEFAULT_MAX_ITERATIONS = 31;
  localparam int CFG_DATA_W             = 5;
  localparam iter_cnt_t ITER_COUNT_RESET = 5'd31;

  // Angle constants in Q4.28, start gain in Q30.
  localparam word_t GAIN_INIT_Q30   = 32'sd652032874;
  localparam word_t HALF_PI_Q28     = 32'sd421657428;
  localparam word_t PI_Q28          = 32'sd843314857;
  localparam word_t ONE_HALF_PI_Q28 = 32'sd1264972285;
  localparam word_t TWO_PI_Q28      = 32'sd1686629713;

  // atan(2^-i) in Q2.30.
  localparam word_t ATAN_TAB [0:30] = '{
    32'sd843314857, 32'sd497837829, 32'sd263043837, 32'sd133525159, 32'sd67021687,
    32'sd33543516,  32'sd16775851,  32'sd8388437,   32'sd4194283,   32'sd2097149,
    32'sd1048576,   32'sd524288,    32'sd262144,    32'sd131072,    32'sd65536,
    32'sd32768,     32'sd16384,     32'sd8192,      32'sd4096,      32'sd2048,
    32'sd1024,      32'sd512,       32'sd256,       32'sd128,       32'sd64,
    32'sd32,        32'sd16,        32'sd8,         32'sd4,         32'sd2,
    32'sd1
  };

endpackage

/* design/cordic_sine_cosine_unit.sv */
// CORDIC sine and cosine unit: angle folding, unrolled rotation pipeline and output scaling.
//
// The unit takes one angle per item on the in_ stream (signed Q4.28 radians, nominally
// [-2pi, 2pi)) and returns one item on the out_ stream holding the cosine, the sine and
// the residual angle left after the last micro-rotation (Q2.30). The angle is first
// folded into [-pi/2, pi/2]: between pi/2 and 1.5pi in magnitude, pi is moved towards
// zero and both results are negated; beyond 1.5pi, 2pi is moved towards zero. All
// arithmetic wraps as 32-bit two's complement. Each CORDIC micro-rotation has a
// register stage of its own; before them lies a fold stage, after them a sign stage
// and the output register. An item can be accepted in every cycle while the output
// register is not stalled. Stages beyond the configured iteration count
// simply pass their item on. The whole pipeline advances together: when the output
// register holds an item that has not been taken, every stage holds and in_tready is
// low. Configuration writes (register 0: iteration count, clamped to MAX_ITERATIONS;
// register 1: short output mode, which rounds and saturates cosine and sine to Q1.15)
// are always accepted, but they must only be made while no item is in flight.
module cordic_sine_cosine_unit #(
  parameter int MAX_ITERATIONS = csc_pkg::DEFAULT_MAX_ITERATIONS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // Input stream.
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [31:0]                    in_tdata,    // [31:0] angle
  // Result stream.
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [95:0]                    out_tdata,   // [31:0] cos_value, [63:32] sin_value,
                                                      // [95:64] residual_angle
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  csc_pkg::cfg_index_t            cfg_index,
  input  logic [csc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import csc_pkg::*;

  // Configuration registers.
  iter_cnt_t iter_count_r;
  logic      short_mode_r;
  iter_cnt_t iter_limit;

  // Pipeline stage registers: index 0 is the folded angle, index k follows k rotations.
  logic  valid_r [0:MAX_ITERATIONS];
  logic  flip_r  [0:MAX_ITERATIONS];
  word_t x_r     [0:MAX_ITERATIONS];
  word_t y_r     [0:MAX_ITERATIONS];
  word_t th_r    [0:MAX_ITERATIONS];

  // Sign stage and output register.
  logic  sgn_valid_r;
  word_t sgn_x_r, sgn_y_r, sgn_th_r;
  logic  out_valid_r;
  word_t out_cos_r, out_sin_r, out_th_r;

  logic  adv;
  word_t angle;
  word_t fold_add;
  word_t fold_th;
  logic  sel_pi, sel_two_pi;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_count_r <= ITER_COUNT_RESET;
      short_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ITERATION_COUNT:   iter_count_r <= cfg_data[4:0];
        CFG_SHORT_OUTPUT_MODE: short_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // A count above the number of built stages runs every stage.
  assign iter_limit = (iter_count_r > iter_cnt_t'(MAX_ITERATIONS)) ?
                      iter_cnt_t'(MAX_ITERATIONS) : iter_count_r;

  // The pipeline moves whenever the output register is empty or being emptied.
  assign adv       = !out_valid_r || out_tready;
  assign in_tready = adv;

  // Fold the angle. The range tests work on the signed angle directly, so the most
  // negative angle counts as magnitude 2^31 and lands in the 2pi band.
  assign angle      = word_t'(in_tdata);
  assign sel_pi     = ((angle > HALF_PI_Q28) && (angle <= ONE_HALF_PI_Q28)) ||
                      ((angle < -HALF_PI_Q28) && (angle >= -ONE_HALF_PI_Q28));
  assign sel_two_pi = (angle > ONE_HALF_PI_Q28) || (angle < -ONE_HALF_PI_Q28);

  always_comb begin
    fold_add = '0;
    if (sel_pi) begin
      fold_add = angle[31] ? PI_Q28 : -PI_Q28;
    end else if (sel_two_pi) begin
      fold_add = angle[31] ? TWO_PI_Q28 : -TWO_PI_Q28;
    end
    fold_th = angle + fold_add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (adv) begin
      valid_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flip_r[0] <= sel_pi;
      x_r[0]    <= GAIN_INIT_Q30;
      y_r[0]    <= '0;
      th_r[0]   <= {fold_th[29:0], 2'b00};
    end
  end

  // One micro-rotation per stage. Stage i rotates by atan(2^-i) towards a zero angle,
  // or passes its item through when i is not below the configured count.
  for (genvar i = 0; i < MAX_ITERATIONS; i++) begin : g_rot
    logic  rot_en;
    logic  dir_neg;
    word_t x_sh, y_sh;

    assign rot_en  = iter_cnt_t'(i) < iter_limit;
    assign dir_neg = th_r[i][31];
    assign x_sh    = x_r[i] >>> i;
    assign y_sh    = y_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i+1] <= 1'b0;
      end else if (adv) begin
        valid_r[i+1] <= valid_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        flip_r[i+1] <= flip_r[i];
        if (!rot_en) begin
          x_r[i+1]  <= x_r[i];
          y_r[i+1]  <= y_r[i];
          th_r[i+1] <= th_r[i];
        end else if (!dir_neg) begin
          x_r[i+1]  <= x_r[i] - y_sh;
          y_r[i+1]  <= y_r[i] + x_sh;
          th_r[i+1] <= th_r[i] - ATAN_TAB[i];
        end else begin
          x_r[i+1]  <= x_r[i] + y_sh;
          y_r[i+1]  <= y_r[i] - x_sh;
          th_r[i+1] <= th_r[i] + ATAN_TAB[i];
        end
      end
    end
  end

  // Sign stage: undo the pi fold by negating both results.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sgn_valid_r <= 1'b0;
    end else if (adv) begin
      sgn_valid_r <= valid_r[MAX_ITERATIONS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sgn_x_r  <= flip_r[MAX_ITERATIONS] ? -x_r[MAX_ITERATIONS] : x_r[MAX_ITERATIONS];
      sgn_y_r  <= flip_r[MAX_ITERATIONS] ? -y_r[MAX_ITERATIONS] : y_r[MAX_ITERATIONS];
      sgn_th_r <= th_r[MAX_ITERATIONS];
    end
  end

  // Short mode: round Q2.30 to Q1.15 as ((v >>> 14) + 1) >>> 1, then saturate.
  function automatic word_t to_q15(input word_t v);
    logic signed [18:0] rnd;
    logic signed [17:0] q;
    word_t res;
    rnd = {v[31], v[31:14]} + 19'sd1;
    q   = rnd[18:1];
    if (q > 18'sd32767) begin
      res = 32'sd32767;
    end else if (q < -18'sd32768) begin
      res = -32'sd32768;
    end else begin
      res = word_t'(q);
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= sgn_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cos_r <= short_mode_r ? to_q15(sgn_x_r) : sgn_x_r;
      out_sin_r <= short_mode_r ? to_q15(sgn_y_r) : sgn_y_r;
      out_th_r  <= sgn_th_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_th_r, out_sin_r, out_cos_r};

`include "cordic_sine_cosine_unit_defines.svh"

  `CSC_ASSERT_RST(a_out_empty_after_reset, !rst_n |=> !out_tvalid, "result valid right after reset")
  `CSC_ASSERT_CLK(a_fold_holds_on_stall, (out_tvalid && !out_tready) |=> $stable(valid_r[0]), "fold stage moved while stalled")
  `CSC_ASSERT_CLK(a_cos_q15_range, (out_tvalid && short_mode_r) |-> (out_tdata[31:15] == '0 || out_tdata[31:15] == '1), "cosine outside Q1.15 range")
  `CSC_ASSERT_CLK(a_sin_q15_range, (out_tvalid && short_mode_r) |-> (out_tdata[63:47] == '0 || out_tdata[63:47] == '1), "sine outside Q1.15 range")

endmodule

/* test/cordic_sine_cosine_unit_tb.sv */
// Self-checking testbench for the CORDIC sine and cosine unit.
`timescale 1ns / 100ps

module cordic_sine_cosine_unit_tb;

  // Constants of the rotation, typed in here so that the prediction does not lean on the
  // package. Angles are Q4.28 before the fold, the table is atan(2^-i) in Q2.30.
  localparam int          ROTATION_LIMIT = 31;
  localparam logic [31:0] START_GAIN     = 32'd652032874;
  localparam logic [31:0] HALF_PI        = 32'd421657428;
  localparam logic [31:0] PI             = 32'd843314857;
  localparam logic [31:0] THREE_HALF_PI  = 32'd1264972285;
  localparam logic [31:0] TWO_PI         = 32'd1686629713;
  localparam logic [31:0] LOWEST_ANGLE   = -32'sd1686629713;
  localparam logic [31:0] ARCTAN_Q30 [0:30] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2,
    32'd1
  };

  // One result item, laid out as on out_tdata (cosine in the lowest bits).
  typedef struct packed {
    logic [31:0] res_v;
    logic [31:0] sin_v;
    logic [31:0] cos_v;
  } sincos_t;

  // An angle in flight together with the result it must produce.
  typedef struct packed {
    logic [31:0] angle;
    sincos_t     result;
  } awaited_t;

  // A row of the directed table. Where known is set, the typed result is used as it
  // stands; otherwise the result is worked out by predict_sincos.
  typedef struct packed {
    logic [4:0]  n_iter;
    logic        q15;
    logic [31:0] angle;
    logic        known;
    logic [31:0] cos_v;
    logic [31:0] sin_v;
    logic [31:0] res_v;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 24;
  localparam directed_row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    // Settings after reset, with no register written yet: the fold boundaries and the
    // ends of the nominal angle range.
    '{5'd31, 1'b0, 32'd0,               1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, 32'd421657428,       1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, 32'd421657429,       1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, -32'sd421657429,     1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, 32'd843314857,       1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, 32'd1264972285,      1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, 32'd1264972286,      1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, -32'sd1264972286,    1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, 32'd1686629712,      1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b0, -32'sd1686629713,    1'b0, 32'd0, 32'd0, 32'd0},
    // No rotation at all: the start gain comes straight out, negated after a fold by pi.
    '{5'd0,  1'b0, 32'd0,               1'b1, 32'd652032874,   32'd0, 32'd0},
    '{5'd0,  1'b0, 32'd843314857,       1'b1, -32'sd652032874, 32'd0, 32'd0},
    '{5'd0,  1'b0, -32'sd843314857,     1'b1, -32'sd652032874, 32'd0, 32'd0},
    '{5'd0,  1'b0, -32'sd1686629713,    1'b1, 32'd652032874,   32'd0, 32'd0},
    // Angles far out of range, where the fold and the shift wrap.
    '{5'd0,  1'b0, 32'h7fff_ffff,       1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd0,  1'b0, 32'h8000_0000,       1'b0, 32'd0, 32'd0, 32'd0},
    // Start gain rounded to Q1.15.
    '{5'd0,  1'b1, 32'd0,               1'b1, 32'd19898,       32'd0, 32'd0},
    '{5'd0,  1'b1, 32'd843314857,       1'b1, -32'sd19898,     32'd0, 32'd0},
    // Full rotation in short mode: a cosine of one saturates.
    '{5'd31, 1'b1, 32'd0,               1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b1, 32'd843314857,       1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b1, 32'h7fff_ffff,       1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd31, 1'b1, 32'h8000_0000,       1'b0, 32'd0, 32'd0, 32'd0},
    // A single micro-rotation.
    '{5'd1,  1'b0, 32'd123456789,       1'b0, 32'd0, 32'd0, 32'd0},
    '{5'd1,  1'b0, -32'sd123456789,     1'b0, 32'd0, 32'd0, 32'd0}
  };

  localparam string FIELD_NAMES [0:2] = '{"cos_value", "sin_value", "residual_angle"};

  // Every input is known from time zero on.
  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata   = '0;   // [31:0] angle
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [95:0]                    out_tdata;         // [31:0] cos_value, [63:32] sin_value,
                                                     // [95:64] residual_angle
  logic                           cfg_valid  = 1'b0;
  logic                           cfg_ready;
  csc_pkg::cfg_index_t            cfg_index  = csc_pkg::CFG_ITERATION_COUNT;
  logic [csc_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  // Copy of the two registers as last written, starting from their reset values.
  logic [4:0] cur_iters = 5'd31;
  logic       cur_q15   = 1'b0;

  // Longest wait, in cycles, that the sender and the receiver draw for each item.
  int tx_idle_max = 6;
  int rx_idle_max = 6;

  awaited_t pending_results [$];
  int       mismatch_count = 0;
  awaited_t oldest;
  sincos_t  observed;

  cordic_sine_cosine_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Rounds a Q2.30 value to Q1.15 (half up, by shifting) and saturates it.
  function automatic logic [31:0] round_sat_q15(input logic [31:0] v);
    logic signed [31:0] t;
    t = ($signed(v) >>> 14) + 32'sd1;
    t = t >>> 1;
    if (t > 32767) begin
      t = 32767;
    end else if (t < -32768) begin
      t = -32768;
    end
    return t;
  endfunction

  // Works out the result item for one angle under the given register settings. All
  // arithmetic is 32 bits wide and wraps, as in the unit.
  function automatic sincos_t predict_sincos(input logic [31:0] angle,
                                             input logic [4:0] n_iter, input logic q15);
    logic [31:0] th, mag, x, y, xs, ys;
    logic        flip;
    int          steps, i;
    sincos_t     r;
    th   = angle;
    // Unsigned magnitude, so that the most negative angle counts as 2^31.
    mag  = th[31] ? 32'd0 - th : th;
    flip = 1'b0;
    if (mag > HALF_PI) begin
      if (mag <= THREE_HALF_PI) begin
        th   = th[31] ? th + PI : th - PI;
        flip = 1'b1;
      end else begin
        th = th[31] ? th + TWO_PI : th - TWO_PI;
      end
    end
    th    = th << 2;
    steps = (n_iter > ROTATION_LIMIT) ? ROTATION_LIMIT : int'(n_iter);
    x  = START_GAIN;
    y  = '0;
    xs = START_GAIN;
    ys = '0;
    for (i = 0; i < steps; i++) begin
      if (!th[31]) begin
        th = th - ARCTAN_Q30[i];
        x  = x - ys;
        y  = y + xs;
      end else begin
        th = th + ARCTAN_Q30[i];
        x  = x + ys;
        y  = y - xs;
      end
      xs = $signed(x) >>> (i + 1);
      ys = $signed(y) >>> (i + 1);
    end
    if (flip) begin
      x = 32'd0 - x;
      y = 32'd0 - y;
    end
    if (q15) begin
      x = round_sat_q15(x);
      y = round_sat_q15(y);
    end
    r.cos_v = x;
    r.sin_v = y;
    r.res_v = th;
    return r;
  endfunction

  // Random angle: mostly within [-2pi, 2pi), some just either side of a fold boundary
  // (where the nominal range is also left), and some anywhere in the 32-bit range.
  function automatic logic [31:0] random_angle();
    logic [31:0] base;
    logic [31:0] a;
    case ($urandom_range(9, 0))
      7, 8: begin
        case ($urandom_range(4, 0))
          0:       base = '0;
          1:       base = HALF_PI;
          2:       base = PI;
          3:       base = THREE_HALF_PI;
          default: base = TWO_PI;
        endcase
        a = base + $urandom_range(4, 0) - 32'd2;
        if ($urandom_range(1, 0) == 1) begin
          a = 32'd0 - a;
        end
      end
      9:       a = $urandom;
      default: a = LOWEST_ANGLE + $urandom_range(32'd3373259425, 0);
    endcase
    return a;
  endfunction

  task automatic wait_all_results();
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Registers are only written with the pipeline empty. As every item yields exactly one
  // result, an empty queue of awaited results means nothing is left in flight; the
  // extra wait is a margin only.
  task automatic set_config(input logic [4:0] n_iter, input logic q15);
    in_tvalid <= 1'b0;
    wait_all_results();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= csc_pkg::CFG_ITERATION_COUNT;
    cfg_data  <= n_iter;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= csc_pkg::CFG_SHORT_OUTPUT_MODE;
    cfg_data  <= {4'b0000, q15};
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_iters = n_iter;
    cur_q15   = q15;
  endtask

  // Offers one angle after a random gap and records what it must produce once taken.
  // With no gap the valid simply stays high into the next item.
  task automatic send_angle(input logic [31:0] angle, input logic known,
                            input sincos_t typed);
    int       gap;
    awaited_t entry;
    gap = $urandom_range(tx_idle_max, 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= angle;
    do @(posedge clk); while (!in_tready);
    entry.angle  = angle;
    entry.result = known ? typed : predict_sincos(angle, cur_iters, cur_q15);
    pending_results.push_back(entry);
  endtask

  task automatic run_phase(input logic [4:0] n_iter, input logic q15, input int count,
                           input int tx_max, input int rx_max);
    int k;
    set_config(n_iter, q15);
    tx_idle_max = tx_max;
    rx_idle_max = rx_max;
    for (k = 0; k < count; k++) begin
      send_angle(random_angle(), 1'b0, '0);
    end
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s", $time, msg);
    end
  endtask

  // Receiver: draws a stall for every item, then holds tready high until an item is taken.
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = $urandom_range(rx_idle_max, 0);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Every result item taken is compared, field by field, with the oldest awaited one.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      observed = out_tdata;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %h arrived with none awaited", out_tdata));
      end else begin
        oldest = pending_results.pop_front();
        for (int f = 0; f < 3; f++) begin
          if (observed[32*f +: 32] !== oldest.result[32*f +: 32]) begin
            report_mismatch($sformatf("angle %h: %s expected %h, got %h", oldest.angle,
                                      FIELD_NAMES[f], oldest.result[32*f +: 32],
                                      observed[32*f +: 32]));
          end
        end
      end
    end
  end

  // Stimulus: the directed table first, then random phases under several settings,
  // the extremes of both registers among them. Each change of settings drains the unit.
  initial begin
    int            k;
    directed_row_t row;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    for (k = 0; k < DIRECTED_ROWS; k++) begin
      row = DIRECTED[k];
      if (row.n_iter != cur_iters || row.q15 != cur_q15) begin
        set_config(row.n_iter, row.q15);
      end
      send_angle(row.angle, row.known, {row.res_v, row.sin_v, row.cos_v});
    end

    run_phase(5'd31, 1'b0, 150, 6, 6);
    run_phase(5'd0,  1'b1, 60,  6, 0);
    run_phase(5'd31, 1'b1, 120, 0, 6);
    run_phase(5'd1,  1'b0, 60,  3, 3);
    run_phase(5'($urandom_range(30, 2)), 1'($urandom_range(1, 0)), 100, 6, 6);
    // A stretch with neither side idling, so that the pipeline runs full.
    run_phase(5'd31, 1'b0, 100, 0, 0);
    run_phase(5'($urandom_range(30, 2)), 1'b1, 110, 6, 6);

    in_tvalid <= 1'b0;
    wait_all_results();
    // Room for anything stray to come out of the pipeline.
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/csc_pkg.sv
design/cordic_sine_cosine_unit.sv
test/cordic_sine_cosine_unit_tb.sv
